@@ sv/p80enc_pkg.sv @@
// p80enc_pkg: shared types, register indexes and round functions for the PRESENT-80 encryptor.
// No dependencies.
`default_nettype none

package p80enc_pkg;

    localparam int unsigned BlockWidth  = 64;
    localparam int unsigned KeyWidth    = 80;
    localparam int unsigned RcWidth     = 5;
    localparam int unsigned AddrWidth   = 4;
    localparam int unsigned DataWidth   = 64;
    localparam int unsigned LowerWidth  = 16;
    localparam int unsigned NibbleCount = BlockWidth / 4;

    typedef enum logic [0:0] {
        REG_KEY_UPPER = 1'b0,
        REG_KEY_LOWER = 1'b1
    } p80enc_reg_t;

    typedef struct packed {
        logic [BlockWidth-1:0] state;
        logic [KeyWidth-1:0]   key;
    } p80enc_item_t;

    typedef logic [3:0] nibble_t;

    function automatic nibble_t sbox(input nibble_t x);
        nibble_t y;
        case (x)
            4'h0: y = 4'hC;
            4'h1: y = 4'h5;
            4'h2: y = 4'h6;
            4'h3: y = 4'hB;
            4'h4: y = 4'h9;
            4'h5: y = 4'h0;
            4'h6: y = 4'hA;
            4'h7: y = 4'hD;
            4'h8: y = 4'h3;
            4'h9: y = 4'hE;
            4'hA: y = 4'hF;
            4'hB: y = 4'h8;
            4'hC: y = 4'h4;
            4'hD: y = 4'h7;
            4'hE: y = 4'h1;
            4'hF: y = 4'h2;
            default: y = 4'h0;
        endcase
        return y;
    endfunction

    function automatic logic [BlockWidth-1:0] sbox_layer(input logic [BlockWidth-1:0] s);
        logic [BlockWidth-1:0] r;
        r = '0;
        for (int n = 0; n < NibbleCount; n++) begin
            r[4*n +: 4] = sbox(s[4*n +: 4]);
        end
        return r;
    endfunction

    // bit i moves to 16*i mod 63 (6-bit rotate left by 4), bit 63 stays
    function automatic logic [BlockWidth-1:0] perm_layer(input logic [BlockWidth-1:0] s);
        logic [BlockWidth-1:0] r;
        logic [5:0]            src;
        r = '0;
        for (int i = 0; i < BlockWidth - 1; i++) begin
            src = 6'(i);
            r[{src[1:0], src[5:2]}] = s[i];
        end
        r[BlockWidth-1] = s[BlockWidth-1];
        return r;
    endfunction

    function automatic logic [KeyWidth-1:0] key_update(input logic [KeyWidth-1:0] k,
                                                       input logic [RcWidth-1:0] rc);
        logic [KeyWidth-1:0] r;
        r = {k[18:0], k[KeyWidth-1:19]};
        r[KeyWidth-1 -: 4] = sbox(r[KeyWidth-1 -: 4]);
        r[19:15] = r[19:15] ^ rc;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ sv/p80enc_regs.sv @@
// p80enc_regs: APB key registers for the PRESENT-80 encryptor.
// Depends on p80enc_pkg.
`default_nettype none

module p80enc_regs (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [p80enc_pkg::AddrWidth-1:0] paddr,
    input  wire logic [p80enc_pkg::DataWidth-1:0] pwdata,
    output logic      [p80enc_pkg::DataWidth-1:0] prdata,
    output logic                                 pready,
    output logic      [p80enc_pkg::KeyWidth-1:0]  key
);
    import p80enc_pkg::*;

    logic [63:0]           key_upper_reg;
    logic [LowerWidth-1:0] key_lower_reg;
    logic                  wr_en;
    p80enc_reg_t           sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = p80enc_reg_t'(paddr[3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end else if (wr_en) begin
            case (sel)
                REG_KEY_UPPER: key_upper_reg <= pwdata;
                REG_KEY_LOWER: key_lower_reg <= pwdata[LowerWidth-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (sel)
            REG_KEY_UPPER: prdata = key_upper_reg;
            REG_KEY_LOWER: prdata = {{(DataWidth-LowerWidth){1'b0}}, key_lower_reg};
            default:       prdata = '0;
        endcase
    end

    assign key = {key_upper_reg, key_lower_reg};

endmodule

`default_nettype wire

@@ sv/p80enc_round.sv @@
// p80enc_round: one registered cipher round with its key schedule step.
// Depends on p80enc_pkg.
`default_nettype none

module p80enc_round #(
    parameter int unsigned ROUND_IDX = 1
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire p80enc_pkg::p80enc_item_t in_item,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output p80enc_pkg::p80enc_item_t      out_item
);
    import p80enc_pkg::*;

    localparam logic [RcWidth-1:0] Rc = RcWidth'(ROUND_IDX);

    logic         valid_reg;
    p80enc_item_t item_reg;
    p80enc_item_t item_next;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        item_next.state = perm_layer(sbox_layer(in_item.state ^ in_item.key[KeyWidth-1 -: 64]));
        item_next.key   = key_update(in_item.key, Rc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

`default_nettype wire

@@ sv/present80_block_encrypt_top.sv @@
// present80_block_encrypt_top: PRESENT-80 block encryptor, one round per pipeline stage.
// Depends on p80enc_pkg, p80enc_regs, p80enc_round.
//
//   channel   dir   beat
//   s_axis    in    tdata[63:0] plaintext_block
//   m_axis    out   tdata[63:0] ciphertext_block
//   apb       in    key_upper @0x0, key_lower @0x8
//
// One stage per round; one beat per cycle is accepted unless m_tready stalls the pipeline.
// The key travels down the pipeline with each block; whitening follows the last stage.
// Reset (synchronous, aresetn low) clears stage valid bits and both key registers.
// A stall holds each occupied stage with no empty stage below it; empty stages keep filling.
`default_nettype none

module present80_block_encrypt_top #(
    parameter int unsigned ROUND_COUNT = 31
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [63:0]                     s_tdata,   // [63:0] plaintext_block
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic      [63:0]                     m_tdata,   // [63:0] ciphertext_block
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [p80enc_pkg::AddrWidth-1:0] paddr,
    input  wire logic [p80enc_pkg::DataWidth-1:0] pwdata,
    output logic      [p80enc_pkg::DataWidth-1:0] prdata,
    output logic                                 pready
);
    import p80enc_pkg::*;

    logic [KeyWidth-1:0] key;
    logic                vld [ROUND_COUNT+1];
    logic                rdy [ROUND_COUNT+1];
    p80enc_item_t        itm [ROUND_COUNT+1];

    p80enc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    assign vld[0]       = s_tvalid;
    assign s_tready     = rdy[0];
    assign itm[0].state = s_tdata;
    assign itm[0].key   = key;

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        p80enc_round #(
            .ROUND_IDX (g + 1)
        ) u_round (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (vld[g]),
            .in_ready  (rdy[g]),
            .in_item   (itm[g]),
            .out_valid (vld[g+1]),
            .out_ready (rdy[g+1]),
            .out_item  (itm[g+1])
        );
    end

    assign m_tvalid          = vld[ROUND_COUNT];
    assign rdy[ROUND_COUNT]  = m_tready;
    assign m_tdata           = itm[ROUND_COUNT].state ^ itm[ROUND_COUNT].key[KeyWidth-1 -: 64];

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for present80_block_encrypt_top, PRESENT-80 encryption over a stream.
// Depends on p80enc_pkg and the RTL top level; holds its own cipher predictor and key copy.
`timescale 1ns / 100ps

module tb;
    import p80enc_pkg::*;

    localparam int unsigned ROUND_COUNT = 31;
    // S-box as a nibble ROM, entry x at bits 4x+3..4x
    localparam logic [63:0] SBOX_ROM = 64'h2174_8FE3_DA09_B65C;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata = '0;   // [63:0] plaintext_block
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [63:0]          m_tdata;        // [63:0] ciphertext_block
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [AddrWidth-1:0] paddr = '0;
    logic [DataWidth-1:0] pwdata = '0;
    logic [DataWidth-1:0] prdata;
    logic                 pready;

    logic [KeyWidth-1:0]  cipher_key = '0;
    logic [63:0]          pending_ciphertext[$];
    logic [63:0]          want_ciphertext;
    int                   mismatch_count = 0;
    int                   src_idle_pct = 0;
    int                   sink_stall_pct = 0;

    present80_block_encrypt_top #(
        .ROUND_COUNT(ROUND_COUNT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [63:0] present80_encrypt(input logic [63:0] pt,
                                                      input logic [79:0] key);
        logic [63:0] st;
        logic [63:0] mixed;
        logic [79:0] rk;
        st = pt;
        rk = key;
        for (int r = 1; r <= ROUND_COUNT; r++) begin
            mixed = st ^ rk[79:16];
            for (int n = 0; n < 16; n++) begin
                mixed[4*n +: 4] = SBOX_ROM[4*mixed[4*n +: 4] +: 4];
            end
            st[63] = mixed[63];
            for (int i = 0; i < 63; i++) begin
                st[(16 * i) % 63] = mixed[i];
            end
            rk = (rk << 61) | (rk >> 19);
            rk[79:76] = SBOX_ROM[4*rk[79:76] +: 4];
            rk[19:15] = rk[19:15] ^ 5'(r);
        end
        return st ^ rk[79:16];
    endfunction

    // result side: random backpressure, compare each beat with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_ciphertext.size() == 0) begin
                $error("unexpected beat: ciphertext_block actual %h", m_tdata);
                mismatch_count++;
            end else begin
                want_ciphertext = pending_ciphertext.pop_front();
                if (m_tdata !== want_ciphertext) begin
                    $error("ciphertext_block expected %h actual %h", want_ciphertext, m_tdata);
                    mismatch_count++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic apb_write(input p80enc_reg_t idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrWidth'(8 * int'(idx));
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (idx == REG_KEY_UPPER)
            cipher_key[79:16] = value;
        else
            cipher_key[15:0] = value[15:0];
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic load_key(input logic [63:0] upper, input logic [63:0] lower_word);
        apb_write(REG_KEY_UPPER, upper);
        apb_write(REG_KEY_LOWER, lower_word);
    endtask

    task automatic send_block(input logic [63:0] pt);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pt;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_ciphertext.push_back(present80_encrypt(pt, cipher_key));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_ciphertext.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_plaintext();
        case ($urandom_range(7))
            0: return 64'h1 << $urandom_range(63);
            1: return ~(64'h1 << $urandom_range(63));
            2: return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0, $urandom};
            default: return rand_word();
        endcase
    endfunction

    // key registers hold zero out of reset
    task automatic test_reset_key();
        send_block(64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        wait_drained();
    endtask

    task automatic test_key_extremes();
        load_key(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_0000_FFFF);
        send_block(64'h0);
        send_block(64'hFFFF_FFFF_FFFF_FFFF);
        send_block(64'h5555_5555_5555_5555);
        send_block(64'hAAAA_AAAA_AAAA_AAAA);
        wait_drained();
        // key_lower ignores pwdata above bit 15
        load_key(64'h0, 64'hDEAD_BEEF_CAFE_FFFF);
        send_block(64'h0);
        send_block(64'h8000_0000_0000_0001);
        wait_drained();
        load_key(64'h8000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_0000);
        send_block(64'h0123_4567_89AB_CDEF);
        wait_drained();
    endtask

    task automatic test_walking_bits();
        int pos[4] = '{0, 31, 62, 63};
        load_key(rand_word(), rand_word());
        foreach (pos[k]) begin
            send_block(64'h1 << pos[k]);
            send_block(~(64'h1 << pos[k]));
        end
        wait_drained();
    endtask

    task automatic test_random_stream(input int src_pct, input int sink_pct,
                                      input int count, input bit pause_midway);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        load_key(rand_word(), rand_word());
        for (int k = 0; k < count; k++) begin
            if (pause_midway && k == count / 2)
                wait_drained();
            send_block(rand_plaintext());
        end
        wait_drained();
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_key();
        test_key_extremes();
        test_walking_bits();
        test_random_stream(0, 0, 140, 1'b0);
        test_random_stream(54, 0, 130, 1'b1);
        test_random_stream(0, 54, 130, 1'b0);
        test_random_stream(6, 6, 130, 1'b0);
        repeat (ROUND_COUNT + 8) @(posedge aclk);
        if (mismatch_count == 0 && pending_ciphertext.size() == 0) begin
            $display("No mismatches found");
        end else begin
            if (pending_ciphertext.size() != 0)
                $error("%0d ciphertext beats never arrived", pending_ciphertext.size());
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $error("timeout with %0d beats outstanding", pending_ciphertext.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
